FILE: rtl/core/kprd_pkg.sv
// Package for the key press/release detector.
// Holds the request and result structs, tracking state types and register codes.
// No dependencies.
package kprd_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned HOLD_W  = 8;
  localparam int unsigned POWER_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIM = 2'd3;

  localparam logic [7:0]         PRESCALE_RST  = 8'd2;
  localparam logic [HOLD_W-1:0]  MIN_HOLD_RST  = 8'd1;
  localparam logic [HOLD_W-1:0]  LONG_HOLD_RST = 8'd20;
  localparam logic [POWER_W-1:0] POWER_LIM_RST = 16'd120;
  localparam logic [POWER_W-1:0] POWER_MAX     = 16'hFFFF;
  localparam logic [HOLD_W-1:0]  LONG_FALLBACK = 8'd2;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_LONG    = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key_bits;
  } kprd_in_t;

  typedef struct packed {
    logic             event_valid;
    logic             event_kind;
    logic [IDX_W-1:0] key_index;
    logic             long_flag;
    logic             power_off;
  } kprd_out_t;

  typedef struct packed {
    logic [IDX_W-1:0]  held_index;
    logic [HOLD_W-1:0] hold_count;
    logic              long_marked;
    logic              invalid_mark;
  } kprd_track_t;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [IDX_W-1:0] index;
    logic             long_flag;
  } kprd_event_t;

endpackage

FILE: rtl/core/kprd_track.sv
// Key tracking update for one processed scan: next held-key state and event.
// Depends on kprd_pkg.
module kprd_track (
  input  kprd_pkg::kprd_track_t            cur,
  input  logic [kprd_pkg::KEY_W-1:0]       bits,
  input  logic [kprd_pkg::HOLD_W-1:0]      min_hold,
  input  logic [kprd_pkg::HOLD_W-1:0]      long_hold,
  output kprd_pkg::kprd_track_t            nxt,
  output kprd_pkg::kprd_event_t            evt
);

  logic [kprd_pkg::KEY_W-1:0]  held_bit;
  logic [kprd_pkg::IDX_W-1:0]  first_idx;
  logic                        multi;
  logic [kprd_pkg::HOLD_W-1:0] hold_inc;

  assign held_bit = kprd_pkg::KEY_W'(1) << (cur.held_index - 5'd1);
  assign multi    = |(bits & (bits - kprd_pkg::KEY_W'(1)));
  assign hold_inc = cur.hold_count + 8'd1;

  // lowest set bit, one-based
  always_comb begin
    first_idx = '0;
    for (int i = kprd_pkg::KEY_W - 1; i >= 0; i--) begin
      if (bits[i]) first_idx = kprd_pkg::IDX_W'(i + 1);
    end
  end

  always_comb begin
    nxt = cur;
    evt = '0;
    if (bits == '0) begin
      if (cur.held_index != '0) begin
        if (cur.hold_count >= min_hold) begin
          evt = '{valid: 1'b1, kind: kprd_pkg::KIND_RELEASE,
                  index: cur.held_index, long_flag: cur.long_marked};
        end
        nxt.held_index = '0;
      end
      nxt.invalid_mark = 1'b0;
    end else begin
      if (cur.held_index != '0) begin
        if ((bits & held_bit) == '0) begin
          if (cur.hold_count >= min_hold) begin
            evt = '{valid: 1'b1, kind: kprd_pkg::KIND_RELEASE,
                    index: cur.held_index, long_flag: cur.long_marked};
          end
          nxt.held_index = '0;
        end else if (!cur.invalid_mark) begin
          if (bits == held_bit) begin
            if (hold_inc == long_hold) begin
              nxt.hold_count  = long_hold - kprd_pkg::LONG_FALLBACK;
              nxt.long_marked = 1'b1;
              evt = '{valid: 1'b1, kind: kprd_pkg::KIND_LONG,
                      index: cur.held_index, long_flag: 1'b1};
            end else begin
              nxt.hold_count = hold_inc;
            end
          end else begin
            nxt.invalid_mark = 1'b1;
          end
        end
      end
      if (!nxt.invalid_mark && nxt.held_index == '0) begin
        if (multi) begin
          nxt.invalid_mark = 1'b1;
        end else begin
          nxt.held_index  = first_idx;
          nxt.long_marked = 1'b0;
          nxt.hold_count  = '0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/key_press_release_detector.sv
// Key press/release detector top level: prescaler, power-off counter, result register.
// Depends on kprd_pkg and kprd_track.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle; the result register takes a new result
// whenever it is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): registers return to defaults, tracking,
// prescaler and power-off state cleared, result register emptied.
module key_press_release_detector #(
  parameter int unsigned KEY_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  kprd_pkg::kprd_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output kprd_pkg::kprd_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [kprd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kprd_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [7:0]                   prescale_div_r;
  logic [kprd_pkg::HOLD_W-1:0]  min_hold_r;
  logic [kprd_pkg::HOLD_W-1:0]  long_hold_r;
  logic [kprd_pkg::POWER_W-1:0] power_lim_r;

  logic [7:0]                   prescale_cnt_r, prescale_cnt_nxt;
  kprd_pkg::kprd_track_t        track_r, track_nxt, track_upd;
  kprd_pkg::kprd_event_t        evt_upd, evt;
  logic [kprd_pkg::POWER_W-1:0] power_cnt_r, power_cnt_nxt;
  logic                         power_req_r, power_req_nxt;
  logic                         out_valid_r;
  kprd_pkg::kprd_out_t          out_data_r, out_data_nxt;

  logic [kprd_pkg::KEY_W-1:0]   key_mask;
  logic [kprd_pkg::KEY_W-1:0]   bits;
  logic [8:0]                   prescale_inc;
  logic                         accept;
  logic                         scan_take;

  always_comb begin
    for (int i = 0; i < kprd_pkg::KEY_W; i++) begin
      key_mask[i] = (i < KEY_COUNT);
    end
  end

  assign bits         = in_data.key_bits & key_mask;
  assign in_ready     = !out_valid_r || out_ready;
  assign accept       = in_valid && in_ready;
  assign prescale_inc = {1'b0, prescale_cnt_r} + 9'd1;
  assign scan_take    = (in_data.mode == kprd_pkg::MODE_TICK) &&
                        !(prescale_inc < {1'b0, prescale_div_r});

  kprd_track u_track (
    .cur       (track_r),
    .bits      (bits),
    .min_hold  (min_hold_r),
    .long_hold (long_hold_r),
    .nxt       (track_upd),
    .evt       (evt_upd)
  );

  always_comb begin
    prescale_cnt_nxt = prescale_cnt_r;
    track_nxt        = track_r;
    power_cnt_nxt    = power_cnt_r;
    power_req_nxt    = power_req_r;
    evt              = '0;
    if (in_data.mode == kprd_pkg::MODE_CLEAR) begin
      track_nxt = '0;
    end else if (!scan_take) begin
      prescale_cnt_nxt = prescale_inc[7:0];
    end else begin
      prescale_cnt_nxt = '0;
      track_nxt        = track_upd;
      evt              = evt_upd;
      if (in_data.key_bits[0]) begin
        if (power_cnt_r != kprd_pkg::POWER_MAX) power_cnt_nxt = power_cnt_r + 16'd1;
        if (power_cnt_nxt > power_lim_r) power_req_nxt = 1'b1;
      end else begin
        power_cnt_nxt = '0;
      end
    end
    out_data_nxt = '{event_valid: evt.valid, event_kind: evt.kind,
                     key_index: evt.index, long_flag: evt.long_flag,
                     power_off: power_req_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_div_r <= kprd_pkg::PRESCALE_RST;
      min_hold_r     <= kprd_pkg::MIN_HOLD_RST;
      long_hold_r    <= kprd_pkg::LONG_HOLD_RST;
      power_lim_r    <= kprd_pkg::POWER_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kprd_pkg::CFG_PRESCALE:  prescale_div_r <= cfg_wdata[7:0];
        kprd_pkg::CFG_MIN_HOLD:  min_hold_r     <= cfg_wdata[7:0];
        kprd_pkg::CFG_LONG_HOLD: long_hold_r    <= cfg_wdata[7:0];
        kprd_pkg::CFG_POWER_LIM: power_lim_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_cnt_r <= '0;
      track_r        <= '0;
      power_cnt_r    <= '0;
      power_req_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        prescale_cnt_r <= prescale_cnt_nxt;
        track_r        <= track_nxt;
        power_cnt_r    <= power_cnt_nxt;
        power_req_r    <= power_req_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
